>>> rtl/smcp_pkg.sv
// Shared constants, codes and types of the serial motion command parser.
`timescale 1ns / 1ps

package smcp_pkg;

  localparam int LINE_BYTES  = 64;
  localparam int FIELD_BYTES = 16;
  localparam int LEN_W       = $clog2(LINE_BYTES);
  localparam int FL_W        = $clog2(FIELD_BYTES + 1);

  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_I     = 8'h49;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_N     = 8'h4E;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_S     = 8'h53;

  localparam int MATCH_S    = 0;
  localparam int MATCH_PING = 1;
  localparam int MATCH_MOVE = 2;

  localparam logic [2:0] CFG_PWM_MIN      = 3'd0;
  localparam logic [2:0] CFG_PWM_MAX      = 3'd1;
  localparam logic [2:0] CFG_DUR_MIN      = 3'd2;
  localparam logic [2:0] CFG_DUR_MAX      = 3'd3;
  localparam logic [2:0] CFG_PWM_DEFAULT  = 3'd4;
  localparam logic [2:0] CFG_DUR_DEFAULT  = 3'd5;

  typedef enum logic [2:0] {
    RESP_MOVE_OK     = 3'd0,
    RESP_STOP        = 3'd1,
    RESP_PONG        = 3'd2,
    RESP_BAD_DIR     = 3'd3,
    RESP_UNKNOWN_CMD = 3'd4
  } resp_e;

  typedef enum logic [1:0] {
    DIR_FORWARD  = 2'd0,
    DIR_BACKWARD = 2'd1,
    DIR_LEFT     = 2'd2,
    DIR_RIGHT    = 2'd3
  } dir_e;

  typedef struct packed {
    logic [6:0]  pwm_min;
    logic [6:0]  pwm_max;
    logic [15:0] duration_min;
    logic [15:0] duration_max;
    logic [7:0]  pwm_default;
    logic [15:0] duration_default;
  } cfg_t;

  typedef struct packed {
    logic [15:0] duration_ms;
    logic [6:0]  pwm_duty;
    dir_e        direction;
    resp_e       response;
  } res_t;

endpackage

>>> rtl/smcp_parser.sv
// Per-byte line parser: running match state, field decode and end-of-line result.
`timescale 1ns / 1ps

module smcp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic [7:0]          byte_i,
  input  smcp_pkg::cfg_t      cfg_i,
  output logic                res_valid_o,
  output smcp_pkg::res_t      res_o
);

  localparam int LEN_W = smcp_pkg::LEN_W;
  localparam int FL_W  = smcp_pkg::FL_W;
  localparam int FS_W  = ((LEN_W > FL_W) ? LEN_W : FL_W) + 1;

  typedef enum logic [5:0] {
    SP_BLANK = 6'b000001,
    SP_INT   = 6'b000010,
    SP_POINT = 6'b000100,
    SP_FRAC1 = 6'b001000,
    SP_FRAC2 = 6'b010000,
    SP_DONE  = 6'b100000
  } speed_phase_e;

  typedef enum logic [2:0] {
    DP_BLANK  = 3'b001,
    DP_DIGITS = 3'b010,
    DP_DONE   = 3'b100
  } dur_phase_e;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic [FL_W-1:0] sat_fl(input logic [FS_W-1:0] v);
    return (v > FS_W'(smcp_pkg::FIELD_BYTES)) ? FL_W'(smcp_pkg::FIELD_BYTES) : v[FL_W-1:0];
  endfunction

  function automatic logic [7:0] sat8(input logic [11:0] v);
    return (v > 12'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [3:0] dir_len(input logic [1:0] k);
    logic [3:0] n;
    case (k)
      2'd0:    n = 4'd7;
      2'd1:    n = 4'd8;
      2'd2:    n = 4'd4;
      default: n = 4'd5;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] dir_char(input logic [1:0] k, input logic [2:0] idx);
    logic [7:0] ch;
    case ({k, idx})
      5'b00_000: ch = "f";
      5'b00_001: ch = "o";
      5'b00_010: ch = "r";
      5'b00_011: ch = "w";
      5'b00_100: ch = "a";
      5'b00_101: ch = "r";
      5'b00_110: ch = "d";
      5'b01_000: ch = "b";
      5'b01_001: ch = "a";
      5'b01_010: ch = "c";
      5'b01_011: ch = "k";
      5'b01_100: ch = "w";
      5'b01_101: ch = "a";
      5'b01_110: ch = "r";
      5'b01_111: ch = "d";
      5'b10_000: ch = "l";
      5'b10_001: ch = "e";
      5'b10_010: ch = "f";
      5'b10_011: ch = "t";
      5'b11_000: ch = "r";
      5'b11_001: ch = "i";
      5'b11_010: ch = "g";
      5'b11_011: ch = "h";
      5'b11_100: ch = "t";
      default:   ch = 8'd0;
    endcase
    return ch;
  endfunction

  logic [LEN_W-1:0] len_q, len_d, pend_q, pend_d;
  logic [1:0]       fi_q, fi_d;
  logic [2:0]       wm_q, wm_d;
  logic [3:0]       mask_q, mask_d;
  logic [FL_W-1:0]  fl_q, fl_d;
  logic [7:0]       sh_q, sh_d;
  speed_phase_e     sp_q, sp_d;
  logic [15:0]      dv_q, dv_d;
  dur_phase_e       dp_q, dp_d;
  logic             saw2_q, saw2_d;
  logic             trunc_q, trunc_d;

  logic [LEN_W-1:0] cr_start;
  logic [LEN_W-1:0] line_len;
  logic [2:0]       wm_c;
  logic [3:0]       mask_c;
  logic [FL_W-1:0]  fl_c;
  speed_phase_e     sp_c;
  dur_phase_e       dp_c;

  logic [3:0]       digit;
  logic [11:0]      sh_first, sh_int;
  logic [8:0]       sh_tenth, sh_unit;
  logic [19:0]      dv_mul;
  logic [7:0]       pwm_sel;
  logic [15:0]      dur_sel;
  logic             take_byte;

  assign digit    = 4'(byte_i - 8'd48);
  assign sh_first = {8'b0, digit} * 12'd100;
  assign sh_int   = ({4'b0, sh_q} * 12'd10) + ({8'b0, digit} * 12'd100);
  assign sh_tenth = {1'b0, sh_q} + ({5'b0, digit} * 9'd10);
  assign sh_unit  = {1'b0, sh_q} + {5'b0, digit};
  assign dv_mul   = ({4'b0, dv_q} * 20'd10) + {16'b0, digit};

  assign take_byte = !trunc_q && (len_q < LEN_W'(smcp_pkg::LINE_BYTES - 1));
  assign cr_start  = len_q - pend_q;
  assign line_len  = len_q - pend_q;

  // fold the pending carriage returns ahead of a content byte
  always_comb begin
    wm_c   = wm_q;
    mask_c = mask_q;
    fl_c   = fl_q;
    sp_c   = sp_q;
    dp_c   = dp_q;
    if (pend_q != '0) begin
      if (cr_start == '0) begin
        wm_c = '0;
      end
      if (cr_start <= LEN_W'(1)) begin
        wm_c[smcp_pkg::MATCH_MOVE] = 1'b0;
        wm_c[smcp_pkg::MATCH_PING] = 1'b0;
      end
      if (cr_start <= LEN_W'(3)) begin
        wm_c[smcp_pkg::MATCH_PING] = 1'b0;
      end
      case (fi_q)
        2'd0: begin
          mask_c = '0;
          fl_c   = sat_fl(FS_W'(fl_q) + FS_W'(pend_q));
        end
        2'd1: begin
          if (sp_q != SP_BLANK) begin
            sp_c = SP_DONE;
          end
          fl_c = sat_fl(FS_W'(fl_q) + FS_W'(pend_q));
        end
        default: begin
          if (dp_q == DP_DIGITS) begin
            dp_c = DP_DONE;
          end
        end
      endcase
    end
  end

  always_comb begin
    len_d   = len_q;
    pend_d  = pend_q;
    fi_d    = fi_q;
    wm_d    = wm_q;
    mask_d  = mask_q;
    fl_d    = fl_q;
    sh_d    = sh_q;
    sp_d    = sp_q;
    dv_d    = dv_q;
    dp_d    = dp_q;
    saw2_d  = saw2_q;
    trunc_d = trunc_q;
    res_valid_o = 1'b0;
    if (byte_valid_i) begin
      if (byte_i == smcp_pkg::CHAR_LF) begin
        res_valid_o = (line_len != '0);
        len_d   = '0;
        pend_d  = '0;
        fi_d    = '0;
        wm_d    = '1;
        mask_d  = '1;
        fl_d    = '0;
        sh_d    = '0;
        sp_d    = SP_BLANK;
        dv_d    = '0;
        dp_d    = DP_BLANK;
        saw2_d  = 1'b0;
        trunc_d = 1'b0;
      end else if (take_byte) begin
        if (byte_i == smcp_pkg::CHAR_NUL) begin
          trunc_d = 1'b1;
        end else if (byte_i == smcp_pkg::CHAR_CR) begin
          pend_d = pend_q + LEN_W'(1);
          len_d  = len_q + LEN_W'(1);
        end else begin
          pend_d = '0;
          len_d  = len_q + LEN_W'(1);
          wm_d   = wm_c;
          mask_d = mask_c;
          fl_d   = fl_c;
          sp_d   = sp_c;
          dp_d   = dp_c;
          if (len_q == '0) begin
            wm_d[smcp_pkg::MATCH_S]    = (byte_i == smcp_pkg::CHAR_S);
            wm_d[smcp_pkg::MATCH_PING] = (byte_i == smcp_pkg::CHAR_P);
            wm_d[smcp_pkg::MATCH_MOVE] = (byte_i == smcp_pkg::CHAR_M);
          end else if (len_q == LEN_W'(1)) begin
            if (byte_i != smcp_pkg::CHAR_COMMA) wm_d[smcp_pkg::MATCH_MOVE] = 1'b0;
            if (byte_i != smcp_pkg::CHAR_I)     wm_d[smcp_pkg::MATCH_PING] = 1'b0;
          end else begin
            if ((len_q == LEN_W'(2)) && (byte_i != smcp_pkg::CHAR_N)) begin
              wm_d[smcp_pkg::MATCH_PING] = 1'b0;
            end
            if ((len_q == LEN_W'(3)) && (byte_i != smcp_pkg::CHAR_G)) begin
              wm_d[smcp_pkg::MATCH_PING] = 1'b0;
            end
            case (fi_q)
              2'd0: begin
                if (byte_i == smcp_pkg::CHAR_COMMA) begin
                  for (int k = 0; k < 4; k++) begin
                    if ((FS_W'(dir_len(2'(k))) != FS_W'(fl_c)) ||
                        (fl_c == FL_W'(smcp_pkg::FIELD_BYTES))) begin
                      mask_d[k] = 1'b0;
                    end
                  end
                  fi_d = 2'd1;
                  fl_d = '0;
                end else begin
                  for (int k = 0; k < 4; k++) begin
                    if ((FS_W'(fl_c) >= FS_W'(dir_len(2'(k)))) ||
                        (dir_char(2'(k), fl_c[2:0]) != byte_i)) begin
                      mask_d[k] = 1'b0;
                    end
                  end
                  fl_d = sat_fl(FS_W'(fl_c) + FS_W'(1));
                end
              end
              2'd1: begin
                if (byte_i == smcp_pkg::CHAR_COMMA) begin
                  fi_d   = 2'd2;
                  saw2_d = 1'b1;
                end else begin
                  fl_d = sat_fl(FS_W'(fl_c) + FS_W'(1));
                  unique case (sp_c)
                    SP_BLANK: begin
                      if (is_blank(byte_i)) begin
                        sp_d = SP_BLANK;
                      end else if (byte_i == smcp_pkg::CHAR_PLUS) begin
                        sp_d = SP_INT;
                      end else if (byte_i == smcp_pkg::CHAR_MINUS) begin
                        sh_d = '0;
                        sp_d = SP_DONE;
                      end else if (is_digit(byte_i)) begin
                        sh_d = sat8(sh_first);
                        sp_d = SP_INT;
                      end else if (byte_i == smcp_pkg::CHAR_POINT) begin
                        sp_d = SP_POINT;
                      end else begin
                        sp_d = SP_DONE;
                      end
                    end
                    SP_INT: begin
                      if (is_digit(byte_i)) begin
                        sh_d = sat8(sh_int);
                      end else if (byte_i == smcp_pkg::CHAR_POINT) begin
                        sp_d = SP_POINT;
                      end else begin
                        sp_d = SP_DONE;
                      end
                    end
                    SP_POINT: begin
                      if (is_digit(byte_i)) begin
                        sh_d = sat8({3'b0, sh_tenth});
                        sp_d = SP_FRAC1;
                      end else begin
                        sp_d = SP_DONE;
                      end
                    end
                    SP_FRAC1: begin
                      if (is_digit(byte_i)) begin
                        sh_d = sat8({3'b0, sh_unit});
                        sp_d = SP_FRAC2;
                      end else begin
                        sp_d = SP_DONE;
                      end
                    end
                    SP_FRAC2: begin
                      if (!is_digit(byte_i)) sp_d = SP_DONE;
                    end
                    default: begin
                      sp_d = SP_DONE;
                    end
                  endcase
                end
              end
              default: begin
                unique case (dp_c)
                  DP_BLANK: begin
                    if (is_blank(byte_i)) begin
                      dp_d = DP_BLANK;
                    end else if (byte_i == smcp_pkg::CHAR_PLUS) begin
                      dp_d = DP_DIGITS;
                    end else if (byte_i == smcp_pkg::CHAR_MINUS) begin
                      dv_d = '0;
                      dp_d = DP_DONE;
                    end else if (is_digit(byte_i)) begin
                      dv_d = {12'b0, digit};
                      dp_d = DP_DIGITS;
                    end else begin
                      dp_d = DP_DONE;
                    end
                  end
                  DP_DIGITS: begin
                    if (is_digit(byte_i)) begin
                      dv_d = (dv_mul > 20'd65535) ? 16'hFFFF : dv_mul[15:0];
                    end else begin
                      dp_d = DP_DONE;
                    end
                  end
                  default: begin
                    dp_d = DP_DONE;
                  end
                endcase
              end
            endcase
          end
        end
      end
    end
  end

  // end-of-line decode from the state left by the line's last content byte
  always_comb begin
    res_o          = '0;
    res_o.response = smcp_pkg::RESP_UNKNOWN_CMD;
    pwm_sel        = cfg_i.pwm_default;
    dur_sel        = cfg_i.duration_default;
    if (saw2_q && (fl_q != '0) && (fl_q < FL_W'(smcp_pkg::FIELD_BYTES))) begin
      pwm_sel = sh_q;
    end
    if (saw2_q) begin
      dur_sel = dv_q;
    end
    if (pwm_sel > {1'b0, cfg_i.pwm_max}) pwm_sel = {1'b0, cfg_i.pwm_max};
    if (pwm_sel < {1'b0, cfg_i.pwm_min}) pwm_sel = {1'b0, cfg_i.pwm_min};
    if (dur_sel > cfg_i.duration_max) dur_sel = cfg_i.duration_max;
    if (dur_sel < cfg_i.duration_min) dur_sel = cfg_i.duration_min;
    if (wm_q[smcp_pkg::MATCH_MOVE] && (line_len > LEN_W'(2))) begin
      if ((fi_q == 2'd0) || (mask_q == 4'd0)) begin
        res_o.response = smcp_pkg::RESP_BAD_DIR;
      end else begin
        res_o.response = smcp_pkg::RESP_MOVE_OK;
        if (mask_q[0]) begin
          res_o.direction = smcp_pkg::DIR_FORWARD;
        end else if (mask_q[1]) begin
          res_o.direction = smcp_pkg::DIR_BACKWARD;
        end else if (mask_q[2]) begin
          res_o.direction = smcp_pkg::DIR_LEFT;
        end else begin
          res_o.direction = smcp_pkg::DIR_RIGHT;
        end
        res_o.pwm_duty    = pwm_sel[6:0];
        res_o.duration_ms = dur_sel;
      end
    end else if (wm_q[smcp_pkg::MATCH_S] && (line_len == LEN_W'(1))) begin
      res_o.response = smcp_pkg::RESP_STOP;
    end else if (wm_q[smcp_pkg::MATCH_PING] && (line_len == LEN_W'(4))) begin
      res_o.response = smcp_pkg::RESP_PONG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      pend_q  <= '0;
      fi_q    <= '0;
      wm_q    <= '1;
      mask_q  <= '1;
      fl_q    <= '0;
      sh_q    <= '0;
      sp_q    <= SP_BLANK;
      dv_q    <= '0;
      dp_q    <= DP_BLANK;
      saw2_q  <= 1'b0;
      trunc_q <= 1'b0;
    end else begin
      len_q   <= len_d;
      pend_q  <= pend_d;
      fi_q    <= fi_d;
      wm_q    <= wm_d;
      mask_q  <= mask_d;
      fl_q    <= fl_d;
      sh_q    <= sh_d;
      sp_q    <= sp_d;
      dv_q    <= dv_d;
      dp_q    <= dp_d;
      saw2_q  <= saw2_d;
      trunc_q <= trunc_d;
    end
  end

endmodule

>>> rtl/serial_motion_command_parser.sv
// Top level of the serial motion command parser: beat registers and configuration.
`timescale 1ns / 1ps

// Takes one received character per input beat and gives one result beat for each LF
// that ends a non-empty line: move, stop, pong or an error code. The block sustains
// one character per clock cycle while no result is stalled; each character is held in
// the input register and is decoded against the line state on its way into the result
// register, which presents the result beat of an LF. The input register is
// refilled in the same cycle as it drains, and the result register parts the sides, so
// a stalled result blocks input only once both registers hold a beat. Nothing needs
// clearing after reset. Configuration writes are taken in any cycle and are meant for
// idle time.
module serial_motion_command_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [2:0] response, [4:3] direction,
                                      // [11:5] pwm_duty, [27:12] duration_ms, rest 0
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic           in_valid_q, in_valid_d;
  logic [7:0]     in_byte_q;
  logic           out_valid_q, out_valid_d;
  smcp_pkg::res_t out_res_q;
  smcp_pkg::cfg_t cfg_q;
  logic           process;
  logic           res_valid;
  smcp_pkg::res_t res;

  assign process       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || process;
  assign cfg_ready_o   = 1'b1;

  assign in_valid_d  = s_axis_tvalid ? 1'b1 : (in_valid_q && !process);
  assign out_valid_d = (process && res_valid) ? 1'b1 : (out_valid_q && !m_axis_tready);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_res_q};

  smcp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (process),
    .byte_i       (in_byte_q),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= s_axis_tready ? in_valid_d : in_valid_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (process && res_valid) begin
      out_res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_min          <= 7'd20;
      cfg_q.pwm_max          <= 7'd100;
      cfg_q.duration_min     <= 16'd50;
      cfg_q.duration_max     <= 16'd5000;
      cfg_q.pwm_default      <= 8'd50;
      cfg_q.duration_default <= 16'd500;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        smcp_pkg::CFG_PWM_MIN:     cfg_q.pwm_min          <= cfg_data_i[6:0];
        smcp_pkg::CFG_PWM_MAX:     cfg_q.pwm_max          <= cfg_data_i[6:0];
        smcp_pkg::CFG_DUR_MIN:     cfg_q.duration_min     <= cfg_data_i;
        smcp_pkg::CFG_DUR_MAX:     cfg_q.duration_max     <= cfg_data_i;
        smcp_pkg::CFG_PWM_DEFAULT: cfg_q.pwm_default      <= cfg_data_i[7:0];
        smcp_pkg::CFG_DUR_DEFAULT: cfg_q.duration_default <= cfg_data_i;
        default: ;
      endcase
    end
  end

  a_res_on_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && res_valid) |-> (in_byte_q == smcp_pkg::CHAR_LF))
    else $error("result raised for a beat that is not LF");

  a_res_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (process && res_valid) |=> m_axis_tvalid)
    else $error("decoded result not presented");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked result");

  a_non_move_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_res_q.response != smcp_pkg::RESP_MOVE_OK)) |->
    ((out_res_q.pwm_duty == 7'd0) && (out_res_q.duration_ms == 16'd0) &&
     (out_res_q.direction == smcp_pkg::DIR_FORWARD)))
    else $error("non-move result carries move fields");

endmodule

>>> verif/motion_command_checker.sv
// Watches the beats of the serial motion command parser, decodes each line and checks every command.
`timescale 1ns / 1ps

module motion_command_checker
  import smcp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  input  logic        rx_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        cmd_valid_i,
  input  logic        cmd_ready_i,
  input  logic [31:0] cmd_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);

  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum int {SP_BLANK, SP_INT, SP_POINT, SP_TENTHS, SP_HUNDREDTHS, SP_DONE} speed_phase_e;
  typedef enum int {DU_BLANK, DU_DIGITS, DU_DONE} dur_phase_e;

  cfg_t         settings;
  int           line_len;
  int           cr_held;
  int           field_no;
  int           field_len;
  logic [2:0]   cmd_live;
  logic [3:0]   dir_live;
  int           speed_hd;
  speed_phase_e speed_phase;
  int           dur_value;
  dur_phase_e   dur_phase;
  bit           second_comma;
  bit           cut_short;
  res_t         expected_cmds [$];
  res_t         got_cmd;
  res_t         want_cmd;

  function automatic bit is_blank(logic [7:0] c);
    return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic int cap(int v, int top);
    return (v > top) ? top : v;
  endfunction

  function automatic string dir_word(int k);
    case (k)
      0:       return "forward";
      1:       return "backward";
      2:       return "left";
      default: return "right";
    endcase
  endfunction

  function void clear_line();
    line_len     = 0;
    cr_held      = 0;
    field_no     = 0;
    field_len    = 0;
    cmd_live     = '1;
    dir_live     = '1;
    speed_hd     = 0;
    speed_phase  = SP_BLANK;
    dur_value    = 0;
    dur_phase    = DU_BLANK;
    second_comma = 1'b0;
    cut_short    = 1'b0;
  endfunction

  function void take_speed(logic [7:0] c);
    int d;
    d = int'(c) - int'(CHAR_ZERO);
    case (speed_phase)
      SP_BLANK: begin
        if (!is_blank(c)) begin
          if (c == CHAR_PLUS) begin
            speed_phase = SP_INT;
          end else if (c == CHAR_MINUS) begin
            speed_hd    = 0;
            speed_phase = SP_DONE;
          end else if (is_digit(c)) begin
            speed_hd    = d * 100;
            speed_phase = SP_INT;
          end else if (c == CHAR_POINT) begin
            speed_phase = SP_POINT;
          end else begin
            speed_phase = SP_DONE;
          end
        end
      end
      SP_INT: begin
        if (is_digit(c)) speed_hd = cap(speed_hd * 10 + d * 100, 255);
        else speed_phase = (c == CHAR_POINT) ? SP_POINT : SP_DONE;
      end
      SP_POINT: begin
        if (is_digit(c)) begin
          speed_hd    = cap(speed_hd + d * 10, 255);
          speed_phase = SP_TENTHS;
        end else begin
          speed_phase = SP_DONE;
        end
      end
      SP_TENTHS: begin
        if (is_digit(c)) begin
          speed_hd    = cap(speed_hd + d, 255);
          speed_phase = SP_HUNDREDTHS;
        end else begin
          speed_phase = SP_DONE;
        end
      end
      SP_HUNDREDTHS: begin
        if (!is_digit(c)) speed_phase = SP_DONE;
      end
      default: ;
    endcase
  endfunction

  function void take_duration(logic [7:0] c);
    int d;
    d = int'(c) - int'(CHAR_ZERO);
    case (dur_phase)
      DU_BLANK: begin
        if (!is_blank(c)) begin
          if (c == CHAR_PLUS) begin
            dur_phase = DU_DIGITS;
          end else if (c == CHAR_MINUS) begin
            dur_value = 0;
            dur_phase = DU_DONE;
          end else if (is_digit(c)) begin
            dur_value = d;
            dur_phase = DU_DIGITS;
          end else begin
            dur_phase = DU_DONE;
          end
        end
      end
      DU_DIGITS: begin
        if (is_digit(c)) dur_value = cap(dur_value * 10 + d, 65535);
        else dur_phase = DU_DONE;
      end
      default: ;
    endcase
  endfunction

  function void take_char(logic [7:0] c, int pos);
    string word;
    if (pos == 0) begin
      cmd_live             = '0;
      cmd_live[MATCH_S]    = (c == CHAR_S);
      cmd_live[MATCH_PING] = (c == CHAR_P);
      cmd_live[MATCH_MOVE] = (c == CHAR_M);
      return;
    end
    if (pos == 1) begin
      if (c != CHAR_COMMA) cmd_live[MATCH_MOVE] = 1'b0;
      if (c != CHAR_I) cmd_live[MATCH_PING] = 1'b0;
      return;
    end
    if ((pos == 2 && c != CHAR_N) || (pos == 3 && c != CHAR_G)) cmd_live[MATCH_PING] = 1'b0;
    if (field_no == 0) begin
      for (int k = 0; k < 4; k++) begin
        word = dir_word(k);
        if (c == CHAR_COMMA) begin
          if (word.len() != field_len || field_len >= FIELD_BYTES) dir_live[k] = 1'b0;
        end else if (field_len >= word.len() || word[field_len] != c) begin
          dir_live[k] = 1'b0;
        end
      end
      if (c == CHAR_COMMA) begin
        field_no  = 1;
        field_len = 0;
      end else begin
        field_len = cap(field_len + 1, FIELD_BYTES);
      end
    end else if (field_no == 1) begin
      if (c == CHAR_COMMA) begin
        field_no     = 2;
        second_comma = 1'b1;
      end else begin
        take_speed(c);
        field_len = cap(field_len + 1, FIELD_BYTES);
      end
    end else begin
      take_duration(c);
    end
  endfunction

  function bit close_line(output res_t cmd);
    int len;
    int pwm;
    int dur;
    len          = line_len - cr_held;
    cmd          = '0;
    cmd.response = RESP_UNKNOWN_CMD;
    if (len == 0) return 1'b0;
    if (cmd_live[MATCH_MOVE] && len > 2) begin
      if (field_no == 0 || dir_live == '0) begin
        cmd.response = RESP_BAD_DIR;
      end else begin
        cmd.response = RESP_MOVE_OK;
        for (int k = 3; k >= 0; k--) begin
          if (dir_live[k]) cmd.direction = dir_e'(k);
        end
        if (second_comma && field_len > 0 && field_len < FIELD_BYTES) pwm = speed_hd;
        else pwm = int'(settings.pwm_default);
        dur = second_comma ? dur_value : int'(settings.duration_default);
        if (pwm > int'(settings.pwm_max)) pwm = int'(settings.pwm_max);
        if (pwm < int'(settings.pwm_min)) pwm = int'(settings.pwm_min);
        if (dur > int'(settings.duration_max)) dur = int'(settings.duration_max);
        if (dur < int'(settings.duration_min)) dur = int'(settings.duration_min);
        cmd.pwm_duty    = pwm[6:0];
        cmd.duration_ms = dur[15:0];
      end
    end else if (cmd_live[MATCH_S] && len == 1) begin
      cmd.response = RESP_STOP;
    end else if (cmd_live[MATCH_PING] && len == 4) begin
      cmd.response = RESP_PONG;
    end
    return 1'b1;
  endfunction

  function void take_rx(logic [7:0] c);
    res_t cmd;
    if (c == CHAR_LF) begin
      if (close_line(cmd)) expected_cmds.push_back(cmd);
      clear_line();
    end else if (!cut_short && line_len < LINE_BYTES - 1) begin
      if (c == CHAR_NUL) begin
        cut_short = 1'b1;
      end else if (c == CHAR_CR) begin
        cr_held++;
        line_len++;
      end else begin
        // release held returns as content once more text follows
        while (cr_held > 0) begin
          take_char(CHAR_CR, line_len - cr_held);
          cr_held--;
        end
        take_char(c, line_len);
        line_len++;
      end
    end
  endfunction

  function void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings = '{pwm_min: 7'd20, pwm_max: 7'd100, duration_min: 16'd50,
                   duration_max: 16'd5000, pwm_default: 8'd50, duration_default: 16'd500};
      clear_line();
      expected_cmds.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PWM_MIN:     settings.pwm_min          = cfg_data_i[6:0];
          CFG_PWM_MAX:     settings.pwm_max          = cfg_data_i[6:0];
          CFG_DUR_MIN:     settings.duration_min     = cfg_data_i;
          CFG_DUR_MAX:     settings.duration_max     = cfg_data_i;
          CFG_PWM_DEFAULT: settings.pwm_default      = cfg_data_i[7:0];
          CFG_DUR_DEFAULT: settings.duration_default = cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_valid_i && cmd_ready_i) begin
        got_cmd = res_t'(cmd_data_i[27:0]);
        if (expected_cmds.size() == 0) begin
          $error("command beat %h with none expected", cmd_data_i);
          errors_o++;
        end else begin
          want_cmd = expected_cmds.pop_front();
          check_field("response", want_cmd.response, got_cmd.response);
          check_field("direction", want_cmd.direction, got_cmd.direction);
          check_field("pwm_duty", want_cmd.pwm_duty, got_cmd.pwm_duty);
          check_field("duration_ms", want_cmd.duration_ms, got_cmd.duration_ms);
          check_field("padding", 0, cmd_data_i[31:28]);
        end
      end
      if (rx_valid_i && rx_ready_i) take_rx(rx_byte_i);
      pending_o = expected_cmds.size();
    end
  end

endmodule

>>> verif/serial_motion_command_parser_tb.sv
// Testbench top of the serial motion command parser: clock, reset, byte and register stimulus, verdict.
`timescale 1ns / 1ps

module serial_motion_command_parser_tb;
  import smcp_pkg::*;

  localparam int         CYCLE_LIMIT = 300000;
  localparam logic [7:0] CHAR_TAB    = 8'd9;
  localparam logic [7:0] CHAR_VT     = 8'd11;
  localparam logic [7:0] CHAR_FF     = 8'd12;
  localparam logic [7:0] CHAR_SPACE  = 8'd32;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index     = CFG_PWM_MIN;
  logic [15:0] cfg_data      = '0;

  int          errors;
  int          pending;
  int          cycles        = 0;
  int          gap_pct       = 0;
  int          stall_pct     = 0;
  int          sent          = 0;
  byte unsigned line_bytes [$];

  serial_motion_command_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  motion_command_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (s_axis_tvalid),
    .rx_ready_i  (s_axis_tready),
    .rx_byte_i   (s_axis_tdata),
    .cmd_valid_i (m_axis_tvalid),
    .cmd_ready_i (m_axis_tready),
    .cmd_data_i  (m_axis_tdata),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL serial_motion_command_parser");
      $finish;
    end
  end

  function automatic logic [7:0] noise_char();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    return (b == CHAR_LF) ? (b ^ 8'h80) : b;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(3))
      0:       return CHAR_TAB;
      1:       return CHAR_VT;
      2:       return CHAR_FF;
      default: return CHAR_SPACE;
    endcase
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endfunction

  function automatic void add_digits(int n);
    repeat (n) line_bytes.push_back(CHAR_ZERO + 8'($urandom_range(9)));
  endfunction

  function automatic void add_direction();
    string word;
    case ($urandom_range(3))
      0:       word = "forward";
      1:       word = "backward";
      2:       word = "left";
      default: word = "right";
    endcase
    if ($urandom_range(99) < 14) begin
      case ($urandom_range(4))
        0:       word = word.substr(0, word.len() - 2);
        1:       word[$urandom_range(word.len() - 1)] = 8'($urandom_range(65, 122));
        2:       word = {word, "s"};
        3:       word = {word, word, word};
        default: word = "";
      endcase
    end
    add_text(word);
  endfunction

  function automatic void add_number(bit is_speed);
    int digits;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 2)) line_bytes.push_back(blank_char());
    end
    case ($urandom_range(19))
      0, 1:    line_bytes.push_back(CHAR_PLUS);
      2:       line_bytes.push_back(CHAR_MINUS);
      default: ;
    endcase
    if ($urandom_range(99) < 8) digits = $urandom_range(4, 9);
    else digits = is_speed ? $urandom_range(0, 2) : $urandom_range(0, 4);
    add_digits(digits);
    if (is_speed && $urandom_range(99) < 45) begin
      line_bytes.push_back(CHAR_POINT);
      add_digits($urandom_range(0, 4));
    end
    if ($urandom_range(99) < 8) line_bytes.push_back(8'($urandom_range(33, 126)));
  endfunction

  function automatic void make_line();
    int kind;
    kind = $urandom_range(99);
    if (kind < 62) begin
      add_text("M,");
      add_direction();
      if ($urandom_range(99) < 92) begin
        line_bytes.push_back(CHAR_COMMA);
        add_number(1'b1);
        if ($urandom_range(99) < 88) begin
          line_bytes.push_back(CHAR_COMMA);
          add_number(1'b0);
        end
      end
    end else if (kind < 70) begin
      add_text("S");
      if ($urandom_range(99) < 20) line_bytes.push_back(noise_char());
    end else if (kind < 78) begin
      add_text(($urandom_range(99) < 80) ? "PING" : "PIN");
      if ($urandom_range(99) < 15) line_bytes.push_back(noise_char());
    end else if (kind < 90) begin
      line_bytes.push_back(CHAR_M);
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(3))
          0:       line_bytes.push_back(CHAR_COMMA);
          1:       add_digits(1);
          2:       add_text("lef");
          default: line_bytes.push_back(noise_char());
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 10)) line_bytes.push_back(noise_char());
    end
    if ($urandom_range(99) < 5) line_bytes.insert($urandom_range(line_bytes.size()), CHAR_CR);
    if ($urandom_range(99) < 3) line_bytes.insert($urandom_range(line_bytes.size()), CHAR_NUL);
    if ($urandom_range(99) < 2) add_digits($urandom_range(60, 75));
    if ($urandom_range(99) < 15) repeat ($urandom_range(1, 2)) line_bytes.push_back(CHAR_CR);
  endfunction

  function automatic cfg_t pick_settings(int ph);
    cfg_t s;
    case (ph)
      0: s = '{pwm_min: 7'd0, pwm_max: 7'd100, duration_min: 16'd0,
               duration_max: 16'd65535, pwm_default: 8'd255, duration_default: 16'd65535};
      1: s = '{pwm_min: 7'd100, pwm_max: 7'd100, duration_min: 16'd65535,
               duration_max: 16'd65535, pwm_default: 8'd0, duration_default: 16'd0};
      2: s = '{pwm_min: 7'd100, pwm_max: 7'd0, duration_min: 16'd65535,
               duration_max: 16'd0, pwm_default: 8'd200, duration_default: 16'd1};
      3: s = '{pwm_min: 7'd20, pwm_max: 7'd100, duration_min: 16'd50,
               duration_max: 16'd5000, pwm_default: 8'd50, duration_default: 16'd500};
      default: begin
        s.pwm_min          = 7'($urandom_range(0, 50));
        s.pwm_max          = 7'($urandom_range(s.pwm_min, 100));
        s.duration_min     = 16'($urandom_range(0, 2000));
        s.duration_max     = 16'($urandom_range(s.duration_min, s.duration_min + 8000));
        s.pwm_default      = 8'($urandom_range(255));
        s.duration_default = 16'($urandom_range(65535));
      end
    endcase
    return s;
  endfunction

  task automatic send_rx(input logic [7:0] b);
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic send_line();
    line_bytes.push_back(CHAR_LF);
    foreach (line_bytes[i]) send_rx(line_bytes[i]);
    line_bytes.delete();
  endtask

  task automatic send_text(input string s);
    add_text(s);
    send_line();
  endtask

  task automatic load_settings(input cfg_t s);
    logic [15:0] vals [6];
    logic [2:0]  regs [6];
    vals = '{16'(s.pwm_min), 16'(s.pwm_max), s.duration_min, s.duration_max,
             16'(s.pwm_default), s.duration_default};
    regs = '{CFG_PWM_MIN, CFG_PWM_MAX, CFG_DUR_MIN, CFG_DUR_MAX,
             CFG_PWM_DEFAULT, CFG_DUR_DEFAULT};
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_directed();
    send_text("S");
    send_text("PING");
    send_text("M,forward,50,1000");
    send_text("M,backward,0.5,10");
    send_text("M,left,-3,-5");
    send_text("M,right,1.239,99999999");
    send_text("M,up,1,1");
    send_text("M");
    send_text("M,");
    send_text("M,,");
    send_text("M,forward");
    send_text("M,forward,");
    send_text("M,left,,");
    send_text("M,left,2.5");
    send_text("M,right, +.75x, +30z");
    send_text("M,backward,.5,7");
    send_text("M,forward,1234567890123456789,5");
    send_text("M,forwardforwardforward,1,1");
    send_text("m,left,1,1");
    send_text("PINGS");
    send_text("");
    // trailing returns, a return inside the line, a lone return
    add_text("S");
    line_bytes.push_back(CHAR_CR);
    line_bytes.push_back(CHAR_CR);
    send_line();
    add_text("S");
    line_bytes.push_back(CHAR_CR);
    send_text("X");
    line_bytes.push_back(CHAR_CR);
    send_line();
    // zero byte cuts the line short
    add_text("P");
    line_bytes.push_back(CHAR_NUL);
    send_text("ING");
    add_text("PING");
    line_bytes.push_back(CHAR_CR);
    line_bytes.push_back(CHAR_NUL);
    send_text("xx");
    // overlong line, top-bit bytes
    repeat (70) line_bytes.push_back(CHAR_M);
    send_line();
    line_bytes.push_back(8'hFF);
    line_bytes.push_back(8'h80);
    send_line();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_directed();
    s_axis_tvalid <= 1'b0;
    settle();
    for (int ph = 0; ph < 6; ph++) begin
      load_settings(pick_settings(ph));
      case (ph % 4)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 61;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 61;
        end
        default: begin
          gap_pct   = 15;
          stall_pct = 15;
        end
      endcase
      sent = 0;
      while (sent < 75) begin
        make_line();
        send_line();
      end
      s_axis_tvalid <= 1'b0;
      settle();
    end
    if (errors == 0 && pending == 0) begin
      $display("PASS serial_motion_command_parser");
    end else begin
      $display("FAIL serial_motion_command_parser");
    end
    $finish;
  end

endmodule
